>>> design/nirpd_pkg.sv
package nirpd_pkg;

   localparam int CFG_W     = 16;
   localparam int CODE_W    = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_HEADER_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_MIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_MAX      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_MIN     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_MAX     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GLITCH_LIMIT = 3'd6;

   localparam logic [CFG_W-1:0] HEADER_MIN_RST   = 16'd0;
   localparam logic [CFG_W-1:0] HEADER_MAX_RST   = 16'hFFFF;
   localparam logic [CFG_W-1:0] ONE_MIN_RST      = 16'd0;
   localparam logic [CFG_W-1:0] ONE_MAX_RST      = 16'd0;
   localparam logic [CFG_W-1:0] ZERO_MIN_RST     = 16'd0;
   localparam logic [CFG_W-1:0] ZERO_MAX_RST     = 16'd0;
   localparam logic [CFG_W-1:0] GLITCH_LIMIT_RST = 16'd3;

   typedef struct packed {
      logic [CFG_W-1:0] header_min;
      logic [CFG_W-1:0] header_max;
      logic [CFG_W-1:0] one_min;
      logic [CFG_W-1:0] one_max;
      logic [CFG_W-1:0] zero_min;
      logic [CFG_W-1:0] zero_max;
      logic [CFG_W-1:0] glitch_limit;
   } cfg_regs_type;

   typedef struct packed {
      logic header;
      logic one;
      logic zero;
      logic above_glitch;
   } win_hit_type;

endpackage

>>> design/nec_ir_pulse_decoder_unit.sv
// An accepted interval goes to the input register; once a frame completes,
// its code goes to the result register on rsp. Throughput: one interval per cycle
// while rsp is not stalled; classify and shift run in one pass.
// Reset (synchronous, active high): idle, both stages empty, window
// registers back to their defaults.
module nec_ir_pulse_decoder_unit #(
   parameter int FRAME_BITS = 32,
   parameter int TICK_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [TICK_WIDTH-1:0]            req_interval_ticks,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [nirpd_pkg::CODE_W-1:0]     rsp_frame_code,
   input  logic                             csr_wr_en,
   input  logic [nirpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nirpd_pkg::CFG_W-1:0]      csr_wdata
);
   import nirpd_pkg::*;

   cfg_regs_type            cfg_ff, cfg_in;
   logic                    in_valid_ff, in_valid_in;
   logic [TICK_WIDTH-1:0]   in_ticks_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]       rsp_code_ff;
   logic                    advance;
   logic                    step;
   logic                    emit;
   logic [CODE_W-1:0]       frame_code;
   win_hit_type             hit;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_HEADER_MIN:   cfg_in.header_min   = csr_wdata;
            REG_HEADER_MAX:   cfg_in.header_max   = csr_wdata;
            REG_ONE_MIN:      cfg_in.one_min      = csr_wdata;
            REG_ONE_MAX:      cfg_in.one_max      = csr_wdata;
            REG_ZERO_MIN:     cfg_in.zero_min     = csr_wdata;
            REG_ZERO_MAX:     cfg_in.zero_max     = csr_wdata;
            REG_GLITCH_LIMIT: cfg_in.glitch_limit = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in  = in_valid_ff && !advance;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end
      rsp_valid_in = (step && emit) || (rsp_valid_ff && rsp_stall);
   end

   nirpd_classify #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_classify (
      .ticks (in_ticks_ff),
      .cfg   (cfg_ff),
      .hit   (hit)
   );

   nirpd_frame #(
      .FRAME_BITS (FRAME_BITS)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .hit        (hit),
      .emit       (emit),
      .frame_code (frame_code)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_min   <= HEADER_MIN_RST;
         cfg_ff.header_max   <= HEADER_MAX_RST;
         cfg_ff.one_min      <= ONE_MIN_RST;
         cfg_ff.one_max      <= ONE_MAX_RST;
         cfg_ff.zero_min     <= ZERO_MIN_RST;
         cfg_ff.zero_max     <= ZERO_MAX_RST;
         cfg_ff.glitch_limit <= GLITCH_LIMIT_RST;
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_valid && !req_stall) begin
         in_ticks_ff <= req_interval_ticks;
      end
      if (step && emit) begin
         rsp_code_ff <= frame_code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_code = rsp_code_ff;

endmodule

>>> design/nirpd_classify.sv
module nirpd_classify #(
   parameter int TICK_WIDTH = 16
) (
   input  logic [TICK_WIDTH-1:0] ticks,
   input  nirpd_pkg::cfg_regs_type cfg,
   output nirpd_pkg::win_hit_type  hit
);
   import nirpd_pkg::*;

   localparam int CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

   logic [CMP_W-1:0] t;

   function automatic logic in_win(input logic [CMP_W-1:0] v,
                                   input logic [CFG_W-1:0] lo,
                                   input logic [CFG_W-1:0] hi);
      logic [CMP_W-1:0] lo_x;
      logic [CMP_W-1:0] hi_x;
      lo_x = CMP_W'(lo);
      hi_x = CMP_W'(hi);
      return (v >= lo_x) && (v <= hi_x);
   endfunction

   always_comb begin
      t                = CMP_W'(ticks);
      hit.header       = in_win(t, cfg.header_min, cfg.header_max);
      hit.one          = in_win(t, cfg.one_min, cfg.one_max);
      hit.zero         = in_win(t, cfg.zero_min, cfg.zero_max);
      hit.above_glitch = t > CMP_W'(cfg.glitch_limit);
   end

endmodule

>>> design/nirpd_frame.sv
module nirpd_frame #(
   parameter int FRAME_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  nirpd_pkg::win_hit_type        hit,
   output logic                          emit,
   output logic [nirpd_pkg::CODE_W-1:0]  frame_code
);
   import nirpd_pkg::*;

   localparam int CNT_W = $clog2(FRAME_BITS + 1);
   localparam int IDX_W = $clog2(FRAME_BITS);

   logic                  receiving_ff, receiving_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [FRAME_BITS-1:0] word_ff, word_in;
   logic [CNT_W-1:0]      count_inc;
   logic [FRAME_BITS-1:0] word_set;

   always_comb begin
      count_inc    = count_ff + CNT_W'(1);
      word_set     = word_ff | (FRAME_BITS'(1) << count_ff[IDX_W-1:0]);
      receiving_in = receiving_ff;
      count_in     = count_ff;
      word_in      = word_ff;
      emit         = 1'b0;
      if (step) begin
         if (!receiving_ff) begin
            if (hit.header) begin
               receiving_in = 1'b1;
               count_in     = '0;
               word_in      = '0;
            end
         end else begin
            priority if (hit.one) begin
               word_in  = word_set;
               count_in = count_inc;
            end else if (hit.zero) begin
               count_in = count_inc;
            end else if (hit.above_glitch) begin
               receiving_in = 1'b0;
               count_in     = '0;
            end else begin
               // drop a short glitch
               count_in = count_ff;
            end
            if ((hit.one || hit.zero) && count_inc == CNT_W'(FRAME_BITS)) begin
               emit         = 1'b1;
               receiving_in = 1'b0;
               count_in     = '0;
            end
         end
      end
      frame_code = CODE_W'(word_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         receiving_ff <= receiving_in;
         count_ff     <= count_in;
      end
      word_ff <= word_in;
   end

endmodule
